// ----- rtl/lscm_pkg.sv -----
// Package for the LED spectrum colour mapper: item types, request and mode
// codes, table sizes and the small arithmetic helpers of the datapath.
// Depends on nothing; used by rtl/led_spectrum_color_mapper.sv.
`timescale 1ns / 1ps

package lscm_pkg;

  // Number of entries in each logical channel's drive curve.
  localparam int unsigned CURVE_DEPTH  = 256;
  localparam int unsigned CURVE_IDX_W  = $clog2(CURVE_DEPTH);
  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned NUM_COLOURS  = 3;
  localparam int unsigned CURVE_ADDR_W = $clog2(NUM_CHANNELS) + CURVE_IDX_W;
  localparam int unsigned CURVE_WORDS  = NUM_CHANNELS << CURVE_IDX_W;

  // Width of the grade-mix dividend: 510 * level + level stays below 2^26.
  localparam int unsigned DIV_W = 26;

  localparam logic [16:0] FULL_LEVEL  = 17'h10000;
  localparam logic [7:0]  DRIVE_MAX   = 8'd255;
  localparam int unsigned GRADE_SCALE = 510;
  localparam logic [24:0] GAIN_ROUND  = 25'd16384;
  localparam logic [27:0] INDEX_ROUND = 28'd32768;

  typedef enum logic [1:0] {
    REQ_MAP   = 2'd0,
    REQ_CURVE = 2'd1,
    REQ_GAIN  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    MODE_DARK      = 3'd0,
    MODE_SOFT      = 3'd1,
    MODE_HARD      = 3'd2,
    MODE_WHITE     = 3'd3,
    MODE_GRADE     = 3'd4,
    MODE_SAFELIGHT = 3'd5,
    MODE_FOCUS     = 3'd6,
    MODE_DARK_ALT  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    CH_SOFT      = 2'd0,
    CH_HARD      = 2'd1,
    CH_SAFELIGHT = 2'd2,
    CH_FOCUS     = 2'd3
  } channel_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  mode;
    logic [16:0] soft_level;
    logic [16:0] hard_level;
    logic [1:0]  table_channel;
    logic [7:0]  table_index;
    logic [15:0] table_value;
  } lscm_req_t;

  typedef struct packed {
    logic [7:0] red_drive;
    logic [7:0] green_drive;
    logic [7:0] blue_drive;
  } lscm_rsp_t;

  typedef logic [NUM_COLOURS-1:0][15:0] lscm_gain_row_t;

  // Addressing and table-write fields, held for the memory access stage only.
  typedef struct packed {
    channel_e               ch_a;
    logic [CURVE_IDX_W-1:0] idx_a;
    logic [CURVE_IDX_W-1:0] idx_b;
    logic [1:0]             wr_ch;
    logic [CURVE_IDX_W-1:0] wr_idx;
    logic [1:0]             wr_col;
    logic [15:0]            wr_val;
  } lscm_acc_t;

  // Fields carried by a map item along the whole pipeline.
  typedef struct packed {
    logic             cal;
    logic             en_a;
    logic             en_b;
    logic             grade;
    logic             soft_ge;
    logic             m_zero;
    lscm_rsp_t        fix;
    logic [DIV_W-1:0] rem;
    logic [17:0]      dv;
    logic [7:0]       quo;
  } lscm_stage_t;

  // Curve index of a level: clamp to full scale, then round to the curve.
  function automatic logic [CURVE_IDX_W-1:0] curve_index(input logic [16:0] level);
    logic [16:0] lvl;
    logic [27:0] scaled;
    lvl    = (level > FULL_LEVEL) ? FULL_LEVEL : level;
    scaled = 28'(lvl) * 28'(CURVE_DEPTH - 1) + INDEX_ROUND;
    return scaled[16 +: CURVE_IDX_W];
  endfunction

  // Two restoring division steps producing quotient bits bit_hi and bit_hi-1.
  function automatic logic [DIV_W+1:0] div_pair(input logic [DIV_W-1:0] rem,
                                                input logic [17:0]      dv,
                                                input int unsigned      bit_hi);
    logic [DIV_W-1:0] r;
    logic [DIV_W-1:0] d;
    logic             qh;
    logic             ql;
    r  = rem;
    d  = DIV_W'(dv) << bit_hi;
    qh = (r >= d);
    if (qh) begin
      r = r - d;
    end
    d  = DIV_W'(dv) << (bit_hi - 1);
    ql = (r >= d);
    if (ql) begin
      r = r - d;
    end
    return {qh, ql, r};
  endfunction

  // Q1.15 gain product: round to nearest and saturate to a drive byte.
  function automatic logic [7:0] scale_round(input logic [23:0] prod);
    logic [24:0] sum;
    sum = 25'(prod) + GAIN_ROUND;
    return (sum[24:15] > 10'(DRIVE_MAX)) ? DRIVE_MAX : sum[22:15];
  endfunction

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? DRIVE_MAX : s[7:0];
  endfunction

endpackage

// ----- rtl/led_spectrum_color_mapper.sv -----
// LED spectrum colour mapper top level: decode, curve and gain memories,
// gain scaling and the pipelined grade-mix divider.
// Depends on rtl/lscm_pkg.sv.
`timescale 1ns / 1ps

// This block turns a light-head command into an 8-bit red, green and blue LED
// drive. It takes one item in every clock cycle: busy_o is always low, so an
// item is accepted at every rising edge at which start_i is high. A map item
// gives exactly one result; curve and gain write items, and the unused request
// code, give none. The result of a map item sits on rsp_o with done_o high for
// one cycle, and results leave in the order in which the items came in. A map
// item passes through the curve and gain memories (address, registered read
// data), the gain multiply and its rounding, and, in the fixed-colour path,
// through the grade-mix division, which produces two quotient bits per stage
// over four stages. The receiver cannot hold results off, and it need not:
// nothing in the block ever stalls. A write item is applied to its table in
// the cycle after its acceptance, the same stage in which a map item reads the
// tables, so a map item always sees every write accepted before it. Curve and
// gain entries must be written before a calibrated map item reads them; the
// tables are not cleared by reset. The calibrated_mode register is written
// through cfg_we_i and cfg_wdata_i; the user must write it only while no item
// is in flight, as the block itself does not enforce this.

module led_spectrum_color_mapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  lscm_pkg::lscm_req_t req_i,
  output logic               done_o,
  output lscm_pkg::lscm_rsp_t rsp_o,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i
);

  // Configuration register.
  logic cal_q;

  // Pipeline control: a map item in each stage, and table writes pending.
  logic v1_q, v2_q, v3_q, v4_q, done_q;
  logic map_d, cwe_d, gwe_d;
  logic cwe_q, gwe_q;

  // Stage payloads.
  lscm_pkg::lscm_acc_t   acc_d, acc_q;
  lscm_pkg::lscm_stage_t st1_d, st1_q;
  lscm_pkg::lscm_stage_t st2_d, st2_q;
  lscm_pkg::lscm_stage_t st3_d, st3_q;
  lscm_pkg::lscm_stage_t st4_d, st4_q;

  // Decode helpers.
  logic        soft_ge;
  logic [16:0] lvl_m;
  logic [16:0] lvl_x;
  logic [16:0] lvl_a;
  logic [16:0] lvl_b;

  // Memories and their registered read data.
  logic [7:0]               curve_mem [lscm_pkg::CURVE_WORDS];
  lscm_pkg::lscm_gain_row_t gain_mem  [lscm_pkg::NUM_CHANNELS];
  logic [7:0]               curve_a_q, curve_b_q;
  lscm_pkg::lscm_gain_row_t gain_a_q, gain_b_q;

  logic [lscm_pkg::CURVE_ADDR_W-1:0] curve_wr_addr;
  logic [lscm_pkg::CURVE_ADDR_W-1:0] curve_rd_a;
  logic [lscm_pkg::CURVE_ADDR_W-1:0] curve_rd_b;

  // Gain products and the calibrated colour.
  logic [lscm_pkg::NUM_COLOURS-1:0][23:0] prod_a_q, prod_b_q;
  logic [lscm_pkg::NUM_COLOURS-1:0][7:0]  cal_rgb_d, cal_rgb_q;

  // Final division step and output selection.
  logic [1:0]                 q_lo;
  logic [lscm_pkg::DIV_W-1:0] fin_rem;
  logic [7:0]                 fin_quo;
  lscm_pkg::lscm_rsp_t        fix_rgb;
  lscm_pkg::lscm_rsp_t        rsp_d, rsp_q;

  // No stage ever waits, so the block is always ready for an item.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Acceptance: decode the mode, work out the curve indices and set up the
  // grade-mix division. The stronger level m always maps to full drive, so
  // only the weaker one needs dividing: floor((510 * x + m) / (2 * m)).
  // ---------------------------------------------------------------------------
  always_comb begin
    map_d = start_i && (req_i.req_type == lscm_pkg::REQ_MAP);
    cwe_d = start_i && (req_i.req_type == lscm_pkg::REQ_CURVE) &&
            (11'(req_i.table_index) < 11'(lscm_pkg::CURVE_DEPTH));
    gwe_d = start_i && (req_i.req_type == lscm_pkg::REQ_GAIN) &&
            (req_i.table_index < 8'(lscm_pkg::NUM_COLOURS));

    soft_ge = (req_i.soft_level >= req_i.hard_level);
    lvl_m   = soft_ge ? req_i.soft_level : req_i.hard_level;
    lvl_x   = soft_ge ? req_i.hard_level : req_i.soft_level;

    st1_d         = '0;
    st1_d.cal     = cal_q;
    st1_d.soft_ge = soft_ge;
    st1_d.m_zero  = (lvl_m == 17'd0);
    st1_d.rem     = lscm_pkg::DIV_W'(lvl_x) * lscm_pkg::DIV_W'(lscm_pkg::GRADE_SCALE) +
                    lscm_pkg::DIV_W'(lvl_m);
    st1_d.dv      = {lvl_m, 1'b0};

    acc_d      = '0;
    acc_d.ch_a = lscm_pkg::CH_SOFT;
    lvl_a      = '0;
    lvl_b      = '0;

    unique case (lscm_pkg::mode_e'(req_i.mode))
      lscm_pkg::MODE_SOFT: begin
        st1_d.fix.green_drive = lscm_pkg::DRIVE_MAX;
        lvl_a = (req_i.soft_level != 17'd0) ? req_i.soft_level : lscm_pkg::FULL_LEVEL;
      end
      lscm_pkg::MODE_HARD: begin
        st1_d.fix.blue_drive = lscm_pkg::DRIVE_MAX;
        acc_d.ch_a = lscm_pkg::CH_HARD;
        lvl_a = (req_i.hard_level != 17'd0) ? req_i.hard_level : lscm_pkg::FULL_LEVEL;
      end
      lscm_pkg::MODE_WHITE: begin
        st1_d.fix.green_drive = lscm_pkg::DRIVE_MAX;
        st1_d.fix.blue_drive  = lscm_pkg::DRIVE_MAX;
        lvl_a = lscm_pkg::FULL_LEVEL;
        lvl_b = lscm_pkg::FULL_LEVEL;
      end
      lscm_pkg::MODE_GRADE: begin
        st1_d.grade = 1'b1;
        lvl_a = req_i.soft_level;
        lvl_b = req_i.hard_level;
      end
      lscm_pkg::MODE_SAFELIGHT: begin
        st1_d.fix.red_drive = lscm_pkg::DRIVE_MAX;
        acc_d.ch_a = lscm_pkg::CH_SAFELIGHT;
        lvl_a = lscm_pkg::FULL_LEVEL;
      end
      lscm_pkg::MODE_FOCUS: begin
        st1_d.fix.red_drive   = lscm_pkg::DRIVE_MAX;
        st1_d.fix.green_drive = lscm_pkg::DRIVE_MAX;
        st1_d.fix.blue_drive  = lscm_pkg::DRIVE_MAX;
        acc_d.ch_a = lscm_pkg::CH_FOCUS;
        lvl_a = lscm_pkg::FULL_LEVEL;
      end
      lscm_pkg::MODE_DARK, lscm_pkg::MODE_DARK_ALT: begin
        lvl_a = '0;
      end
    endcase

    // A channel at level zero contributes nothing.
    st1_d.en_a  = (lvl_a != 17'd0);
    st1_d.en_b  = (lvl_b != 17'd0);
    acc_d.idx_a = lscm_pkg::curve_index(lvl_a);
    acc_d.idx_b = lscm_pkg::curve_index(lvl_b);

    acc_d.wr_ch  = req_i.table_channel;
    acc_d.wr_idx = lscm_pkg::CURVE_IDX_W'(11'(req_i.table_index));
    acc_d.wr_col = req_i.table_index[1:0];
    acc_d.wr_val = req_i.table_value;
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q  <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
      cwe_q  <= 1'b0;
      gwe_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cal_q <= cfg_wdata_i;
      end
      v1_q   <= map_d;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= v4_q;
      cwe_q  <= cwe_d;
      gwe_q  <= gwe_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    st1_q     <= st1_d;
    st2_q     <= st2_d;
    st3_q     <= st3_d;
    st4_q     <= st4_d;
    cal_rgb_q <= cal_rgb_d;
    rsp_q     <= rsp_d;
  end

  // ---------------------------------------------------------------------------
  // Curve and gain memories. Writes and reads are both issued from the first
  // stage, in item order, so a read never races a write to the same entry.
  // The second curve and gain port serves the hard channel in the white and
  // grade-mix modes.
  // ---------------------------------------------------------------------------
  assign curve_wr_addr = {acc_q.wr_ch, acc_q.wr_idx};
  assign curve_rd_a    = {acc_q.ch_a, acc_q.idx_a};
  assign curve_rd_b    = {lscm_pkg::CH_HARD, acc_q.idx_b};

  always_ff @(posedge clk_i) begin
    if (cwe_q) begin
      curve_mem[curve_wr_addr] <= acc_q.wr_val[7:0];
    end
    if (v1_q) begin
      curve_a_q <= curve_mem[curve_rd_a];
      curve_b_q <= curve_mem[curve_rd_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (gwe_q) begin
      gain_mem[acc_q.wr_ch][acc_q.wr_col] <= acc_q.wr_val;
    end
    if (v1_q) begin
      gain_a_q <= gain_mem[acc_q.ch_a];
      gain_b_q <= gain_mem[lscm_pkg::CH_HARD];
    end
  end

  // Curve byte times Q1.15 gain, one product per colour and channel.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < lscm_pkg::NUM_COLOURS; k++) begin
      prod_a_q[k] <= 24'(curve_a_q) * 24'(gain_a_q[k]);
      prod_b_q[k] <= 24'(curve_b_q) * 24'(gain_b_q[k]);
    end
  end

  // Round, saturate and add the two channels with saturation.
  always_comb begin
    for (int k = 0; k < lscm_pkg::NUM_COLOURS; k++) begin
      cal_rgb_d[k] = lscm_pkg::sat_add8(
                       st3_q.en_a ? lscm_pkg::scale_round(prod_a_q[k]) : 8'd0,
                       st3_q.en_b ? lscm_pkg::scale_round(prod_b_q[k]) : 8'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Grade-mix divider: two restoring steps per stage, quotient bits from the
  // top down. The quotient never exceeds 255 because x <= m.
  // ---------------------------------------------------------------------------
  always_comb begin
    st2_d = st1_q;
    {st2_d.quo[7:6], st2_d.rem} = lscm_pkg::div_pair(st1_q.rem, st1_q.dv, 7);
    st3_d = st2_q;
    {st3_d.quo[5:4], st3_d.rem} = lscm_pkg::div_pair(st2_q.rem, st2_q.dv, 5);
    st4_d = st3_q;
    {st4_d.quo[3:2], st4_d.rem} = lscm_pkg::div_pair(st3_q.rem, st3_q.dv, 3);
    {q_lo, fin_rem} = lscm_pkg::div_pair(st4_q.rem, st4_q.dv, 1);
    fin_quo = {st4_q.quo[7:2], q_lo};
  end

  // Output selection: calibrated colour, grade mix or fixed colour.
  always_comb begin
    fix_rgb = st4_q.fix;
    if (st4_q.grade) begin
      fix_rgb = '0;
      if (!st4_q.m_zero) begin
        fix_rgb.green_drive = st4_q.soft_ge ? lscm_pkg::DRIVE_MAX : fin_quo;
        fix_rgb.blue_drive  = st4_q.soft_ge ? fin_quo : lscm_pkg::DRIVE_MAX;
      end
    end
    if (st4_q.cal) begin
      rsp_d.red_drive   = cal_rgb_q[0];
      rsp_d.green_drive = cal_rgb_q[1];
      rsp_d.blue_drive  = cal_rgb_q[2];
    end else begin
      rsp_d = fix_rgb;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  // Every accepted map item yields a result after the fixed latency.
  a_map_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.req_type == lscm_pkg::REQ_MAP) |-> ##5 done_o)
    else $error("map item lost in the pipeline");

  // Table writes and unused requests never produce a result.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(start_i && req_i.req_type == lscm_pkg::REQ_MAP)) |-> ##5 !done_o)
    else $error("result produced without a map item");

  // The access stage holds at most one kind of item.
  a_access_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({v1_q, cwe_q, gwe_q}))
    else $error("access stage holds more than one item");

  // The final grade-mix remainder is below the divisor.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && st4_q.grade && !st4_q.m_zero) |-> (fin_rem < lscm_pkg::DIV_W'(st4_q.dv)))
    else $error("grade-mix division left a remainder too large");
`endif

endmodule
